// ===== hdl/fcct_pkg.sv =====
// fcct_pkg: shared constants, register indexes and types of the fog corner code tracker
// no dependencies; imported by fcct_front, fcct_back and the top level
package fcct_pkg;

    // grid limits of the code store
    localparam int unsigned MAX_ENTRIES_WIDE = 256;
    localparam int unsigned MAX_ENTRIES_HIGH = 256;

    // field widths
    localparam int unsigned COORD_W = 8;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned DARK_W  = 2;
    localparam int unsigned CFG_W   = 8;

    // storage geometry
    localparam int unsigned CODE_DEPTH = MAX_ENTRIES_WIDE * MAX_ENTRIES_HIGH;
    localparam int unsigned ADDR_W     = $clog2(CODE_DEPTH);
    localparam int unsigned COL_AW     = $clog2(MAX_ENTRIES_WIDE);

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_CELLS_WIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_CELLS_HIGH = 1'b1;

    // register reset values
    localparam logic [CFG_W-1:0] MAP_CELLS_WIDE_RST = 8'd64;
    localparam logic [CFG_W-1:0] MAP_CELLS_HIGH_RST = 8'd64;

    // empty box marks
    localparam logic [COORD_W-1:0] BOX_MIN_RST = '1;
    localparam logic [COORD_W-1:0] BOX_MAX_RST = '0;

    // stream word widths
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 64;

    // item handed from the front stage to the code stage
    typedef struct packed {
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [DARK_W-1:0]  se;
        logic               frame_end;
        logic               col_ok;
        logic               cell_ok;
        logic               fwd;
        logic [ADDR_W-1:0]  addr;
    } item_t;

    // write-back request into the code store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] data;
    } code_wr_t;

    // one result word
    typedef struct packed {
        logic [COORD_W-1:0] max_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] min_x;
        logic               any_changed;
        logic               frame_end;
        logic               changed;
        logic [CODE_W-1:0]  code;
        logic [COORD_W-1:0] ey;
        logic [COORD_W-1:0] ex;
    } result_t;

endpackage

// ===== hdl/fcct_ram.sv =====
// fcct_ram: generic simple dual-port ram, one write and one registered read port
// read returns the old data on a same-address write; no dependencies
module fcct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // storage with registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/fcct_front.sv =====
// fcct_front: entry counters, clearing sequencer, previous-row dark store and read issue
// depends on fcct_pkg and fcct_ram
module fcct_front
    import fcct_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         cell_bits,     // explored, visible
    input  logic [CFG_W-1:0]   map_cells_wide,
    input  logic [CFG_W-1:0]   map_cells_high,
    input  logic               back_take,
    input  code_wr_t           back_wr,
    output logic               accept,
    output item_t              item,
    output logic [DARK_W-1:0]  up_dark,
    output logic               clr_active,
    output logic [ADDR_W-1:0]  clr_addr
);

    logic [COORD_W-1:0] ex_reg, ex_next;
    logic [COORD_W-1:0] ey_reg, ey_next;
    logic               clr_reg, clr_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               last_col;
    logic               last_row;
    logic [31:0]        lim_x;
    logic [31:0]        lim_y;
    logic               row_we;
    logic [COL_AW-1:0]  row_waddr;
    logic [DARK_W-1:0]  row_wdata;

    assign s_tready   = !clr_reg && back_take;
    assign accept     = s_tvalid && s_tready;
    assign clr_active = clr_reg;
    assign clr_addr   = clr_cnt_reg;

    // last column and row of the grid, limited to the store
    always_comb begin
        lim_x    = (32'(map_cells_wide) + 32'd1 > MAX_ENTRIES_WIDE) ?
                   MAX_ENTRIES_WIDE - 32'd1 : 32'(map_cells_wide);
        lim_y    = (32'(map_cells_high) + 32'd1 > MAX_ENTRIES_HIGH) ?
                   MAX_ENTRIES_HIGH - 32'd1 : 32'(map_cells_high);
        last_col = 32'(ex_reg) >= lim_x;
        last_row = 32'(ey_reg) >= lim_y;
    end

    // item built from the counters and the input word
    always_comb begin
        item.ex        = ex_reg;
        item.ey        = ey_reg;
        item.se        = '0;
        if (ex_reg < map_cells_wide && ey_reg < map_cells_high) begin
            item.se = ~cell_bits;
        end
        item.frame_end = last_col && last_row;
        item.col_ok    = 32'(ex_reg) < MAX_ENTRIES_WIDE;
        item.cell_ok   = item.col_ok && (32'(ey_reg) < MAX_ENTRIES_HIGH);
        item.addr      = ADDR_W'(ADDR_W'(ey_reg) * ADDR_W'(MAX_ENTRIES_WIDE)) +
                         ADDR_W'(ex_reg);
        // entry written back in this very cycle is taken from the code stage
        item.fwd       = back_wr.en && (back_wr.addr == item.addr);
    end

    // counter advance
    always_comb begin
        ex_next = ex_reg;
        ey_next = ey_reg;
        if (accept) begin
            if (last_col) begin
                ex_next = '0;
                ey_next = item.frame_end ? '0 : ey_reg + 1'b1;
            end else begin
                ex_next = ex_reg + 1'b1;
            end
        end
    end

    // clearing pass over both stores after reset
    always_comb begin
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clr_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(CODE_DEPTH - 1)) begin
                clr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_reg      <= '0;
            ey_reg      <= '0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else begin
            ex_reg      <= ex_next;
            ey_reg      <= ey_next;
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // previous-row dark bits, read before the same item overwrites them
    assign row_we    = clr_reg || (accept && item.col_ok);
    assign row_waddr = clr_reg ? COL_AW'(clr_cnt_reg) : COL_AW'(ex_reg);
    assign row_wdata = clr_reg ? '0 : item.se;

    fcct_ram #(
        .WIDTH (DARK_W),
        .DEPTH (MAX_ENTRIES_WIDE)
    ) u_row_ram (
        .aclk    (aclk),
        .we      (row_we),
        .wr_addr (row_waddr),
        .wr_data (row_wdata),
        .rd_en   (accept),
        .rd_addr (COL_AW'(ex_reg)),
        .rd_data (up_dark)
    );

endmodule

// ===== hdl/fcct_back.sv =====
// fcct_back: code stage; builds the corner code, compares, writes back, tracks the box
// and holds the output register; depends on fcct_pkg
module fcct_back
    import fcct_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  item_t              item,
    input  logic [DARK_W-1:0]  up_dark,
    input  logic [CODE_W-1:0]  stored_rd,
    output logic               back_take,
    output code_wr_t           back_wr,
    output logic               m_tvalid,
    input  logic               m_tready,
    output result_t            result
);

    logic               s1_valid_reg, s1_valid_next;
    item_t              s1_reg;
    logic               s1_adv;
    logic [DARK_W-1:0]  diag_reg, left_reg;
    logic [CODE_W-1:0]  last_code_reg;
    logic [COORD_W-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic [COORD_W-1:0] min_x_next, min_y_next, max_x_next, max_y_next;
    logic               box_valid_reg, box_valid_next;
    logic               m_valid_reg, m_valid_next;
    result_t            res_reg, res_next;
    logic [DARK_W-1:0]  ne, nw, sw;
    logic [CODE_W-1:0]  code;
    logic [CODE_W-1:0]  stored;
    logic               changed;
    logic [COORD_W-1:0] bmin_x, bmin_y, bmax_x, bmax_y;
    logic               bvalid;

    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign back_take = !s1_valid_reg || s1_adv;
    assign m_tvalid  = m_valid_reg;
    assign result    = res_reg;

    // corner code and compare
    always_comb begin
        ne = (s1_reg.ey != '0 && s1_reg.col_ok) ? up_dark : '0;
        nw = (s1_reg.ex != '0) ? diag_reg : '0;
        sw = (s1_reg.ex != '0) ? left_reg : '0;
        code = {s1_reg.se[1], sw[1], ne[1], nw[1], s1_reg.se[0], sw[0], ne[0], nw[0]};
        stored = '0;
        if (s1_reg.cell_ok) begin
            stored = s1_reg.fwd ? last_code_reg : stored_rd;
        end
        changed = code != stored;
    end

    // write-back
    always_comb begin
        back_wr.en   = s1_adv && s1_reg.cell_ok;
        back_wr.addr = s1_reg.addr;
        back_wr.data = code;
    end

    // box of changed entries including this one
    always_comb begin
        bmin_x = min_x_reg;
        bmin_y = min_y_reg;
        bmax_x = max_x_reg;
        bmax_y = max_y_reg;
        bvalid = box_valid_reg;
        if (changed) begin
            if (!box_valid_reg) begin
                bmin_x = s1_reg.ex;
                bmax_x = s1_reg.ex;
                bmin_y = s1_reg.ey;
                bmax_y = s1_reg.ey;
                bvalid = 1'b1;
            end else begin
                if (s1_reg.ex < min_x_reg) bmin_x = s1_reg.ex;
                if (s1_reg.ex > max_x_reg) bmax_x = s1_reg.ex;
                if (s1_reg.ey < min_y_reg) bmin_y = s1_reg.ey;
                if (s1_reg.ey > max_y_reg) bmax_y = s1_reg.ey;
            end
        end
    end

    // next box state, emptied at frame end
    always_comb begin
        min_x_next     = min_x_reg;
        min_y_next     = min_y_reg;
        max_x_next     = max_x_reg;
        max_y_next     = max_y_reg;
        box_valid_next = box_valid_reg;
        if (s1_adv) begin
            if (s1_reg.frame_end) begin
                min_x_next     = BOX_MIN_RST;
                min_y_next     = BOX_MIN_RST;
                max_x_next     = BOX_MAX_RST;
                max_y_next     = BOX_MAX_RST;
                box_valid_next = 1'b0;
            end else begin
                min_x_next     = bmin_x;
                min_y_next     = bmin_y;
                max_x_next     = bmax_x;
                max_y_next     = bmax_y;
                box_valid_next = bvalid;
            end
        end
    end

    // result word
    always_comb begin
        res_next             = res_reg;
        if (s1_adv) begin
            res_next.ex          = s1_reg.ex;
            res_next.ey          = s1_reg.ey;
            res_next.code        = code;
            res_next.changed     = changed;
            res_next.frame_end   = s1_reg.frame_end;
            res_next.any_changed = s1_reg.frame_end && bvalid;
            res_next.min_x       = '0;
            res_next.min_y       = '0;
            res_next.max_x       = '0;
            res_next.max_y       = '0;
            if (s1_reg.frame_end && bvalid) begin
                res_next.min_x = bmin_x;
                res_next.min_y = bmin_y;
                res_next.max_x = bmax_x;
                res_next.max_y = bmax_y;
            end
        end
    end

    // stage and output valid
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            diag_reg      <= '0;
            left_reg      <= '0;
            min_x_reg     <= BOX_MIN_RST;
            min_y_reg     <= BOX_MIN_RST;
            max_x_reg     <= BOX_MAX_RST;
            max_y_reg     <= BOX_MAX_RST;
            box_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            m_valid_reg   <= m_valid_next;
            if (s1_adv) begin
                diag_reg <= ne;
                left_reg <= s1_reg.se;
            end
            min_x_reg     <= min_x_next;
            min_y_reg     <= min_y_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
            box_valid_reg <= box_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= item;
        end
        if (s1_adv) begin
            last_code_reg <= code;
        end
        res_reg <= res_next;
    end

endmodule

// ===== hdl/fog_corner_code_change_tracker.sv =====
// fog_corner_code_change_tracker: top level; configuration registers, code store and the
// two pipeline stages; depends on fcct_pkg, fcct_ram, fcct_front and fcct_back
//
// Usage:
//   s_ channel carries one map cell word per corner-grid entry in raster order,
//   (map_cells_wide+1) entries per row by (map_cells_high+1) rows.
//   m_ channel returns one result word per input word, in the same order; m_tlast
//   marks the last entry of the grid, where the changed-entry box is reported and
//   then emptied.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index at the clock
//   edge (0 map_cells_wide, 1 map_cells_high); write only while the block is idle.
// Pipeline:
//   an accepted word is held in the code stage, then in the output register on m_; with
//   m_tready high one word per cycle is sustained, set by the single read and single
//   write port of the code store. Reset: aresetn (synchronous, active low) restarts
//   the counters and empties the box, then a clearing pass zeroes the code store and
//   the row store one entry a cycle; s_tready stays low until every code store entry
//   is cleared.
// Stalls:
//   with m_tready low one finished word waits in the output register and one more in
//   the code stage; outside the clearing pass s_tready drops only once both are full.
module fog_corner_code_change_tracker
    import fcct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input cell words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] explored_bit, [1] visible_bit, rest zero
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] entry_x, [15:8] entry_y,
                                            // [23:16] corner_code, [24] code_changed,
                                            // [25] any_changed, [33:26] changed_min_x,
                                            // [41:34] changed_min_y, [49:42] changed_max_x,
                                            // [57:50] changed_max_y, rest zero
    output logic                 m_tlast,   // frame_end
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0]  map_cells_wide_reg;
    logic [CFG_W-1:0]  map_cells_high_reg;
    logic              accept;
    item_t             item;
    logic [DARK_W-1:0] up_dark;
    logic              clr_active;
    logic [ADDR_W-1:0] clr_addr;
    logic              back_take;
    code_wr_t          back_wr;
    logic [CODE_W-1:0] stored_rd;
    result_t           result;
    logic              code_we;
    logic [ADDR_W-1:0] code_waddr;
    logic [CODE_W-1:0] code_wdata;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_cells_wide_reg <= MAP_CELLS_WIDE_RST;
            map_cells_high_reg <= MAP_CELLS_HIGH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAP_CELLS_WIDE: map_cells_wide_reg <= cfg_wdata;
                REG_MAP_CELLS_HIGH: map_cells_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front stage: counters, row store, clearing
    fcct_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .cell_bits      (s_tdata[1:0]),
        .map_cells_wide (map_cells_wide_reg),
        .map_cells_high (map_cells_high_reg),
        .back_take      (back_take),
        .back_wr        (back_wr),
        .accept         (accept),
        .item           (item),
        .up_dark        (up_dark),
        .clr_active     (clr_active),
        .clr_addr       (clr_addr)
    );

    // code store write port shared by the clearing pass and write-back
    assign code_we    = clr_active || back_wr.en;
    assign code_waddr = clr_active ? clr_addr : back_wr.addr;
    assign code_wdata = clr_active ? '0 : back_wr.data;

    fcct_ram #(
        .WIDTH (CODE_W),
        .DEPTH (CODE_DEPTH)
    ) u_code_ram (
        .aclk    (aclk),
        .we      (code_we),
        .wr_addr (code_waddr),
        .wr_data (code_wdata),
        .rd_en   (accept),
        .rd_addr (item.addr),
        .rd_data (stored_rd)
    );

    // code stage and output register
    fcct_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .item      (item),
        .up_dark   (up_dark),
        .stored_rd (stored_rd),
        .back_take (back_take),
        .back_wr   (back_wr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    // result word packing
    assign m_tdata = {
        (M_TDATA_W - 58)'(0),
        result.max_y, result.max_x, result.min_y, result.min_x,
        result.any_changed, result.changed, result.code, result.ey, result.ex
    };
    assign m_tlast = result.frame_end;

    // no input word is taken while the code store is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active |-> !s_tready)
        else $error("input word accepted during clearing pass");

    // box fields stay zero away from the frame end
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[57:25] == '0)
        else $error("box fields set on a word that is not the frame end");

    // a reported box is ordered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25] |-> (m_tdata[33:26] <= m_tdata[49:42]) &&
                                    (m_tdata[41:34] <= m_tdata[57:50]))
        else $error("reported box has min above max");

    // a change on the last entry always shows in the box
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tdata[24] |-> m_tdata[25])
        else $error("changed last entry missing from box");

endmodule

// ===== tb/sv/fog_corner_code_change_tracker_test.sv =====
// fog_corner_code_change_tracker_test: self-checking testbench of the fog corner code tracker;
// streams cell words through s_, predicts every result word and compares it on m_
// depends on fcct_pkg and the fog_corner_code_change_tracker rtl
module fog_corner_code_change_tracker_test;
    import fcct_pkg::*;

    // no word moving for this long ends the run; covers the clearing pass after reset
    localparam int unsigned WATCHDOG_CYCLES = 200000;
    localparam int unsigned PRINT_LIMIT     = 60;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    // one result word split into its fields
    typedef struct {
        bit [COORD_W-1:0] ex;
        bit [COORD_W-1:0] ey;
        bit [CODE_W-1:0]  code;
        bit               changed;
        bit               frame_end;
        bit               any_changed;
        bit [COORD_W-1:0] min_x;
        bit [COORD_W-1:0] min_y;
        bit [COORD_W-1:0] max_x;
        bit [COORD_W-1:0] max_y;
    } corner_word_t;

    string field_names [10] = '{"entry_x", "entry_y", "corner_code", "code_changed",
                                "frame_end", "any_changed", "changed_min_x",
                                "changed_min_y", "changed_max_x", "changed_max_y"};

    // tracker state as the testbench sees it
    bit [CODE_W-1:0]  code_mem [CODE_DEPTH];
    bit [DARK_W-1:0]  row_dark [MAX_ENTRIES_WIDE];
    bit [DARK_W-1:0]  left_dark;
    bit [DARK_W-1:0]  diag_dark;
    bit [COORD_W-1:0] grid_col;
    bit [COORD_W-1:0] grid_row;
    bit [COORD_W-1:0] box_min_x = BOX_MIN_RST;
    bit [COORD_W-1:0] box_min_y = BOX_MIN_RST;
    bit [COORD_W-1:0] box_max_x = BOX_MAX_RST;
    bit [COORD_W-1:0] box_max_y = BOX_MAX_RST;
    bit               box_valid;
    bit [CFG_W-1:0]   grid_wide = MAP_CELLS_WIDE_RST;
    bit [CFG_W-1:0]   grid_high = MAP_CELLS_HIGH_RST;

    // fog map that the cell words are read from, {visible, explored} per cell
    bit [1:0] fog_map [256][256];

    corner_word_t pending_words [$];
    int unsigned  mismatches;
    int unsigned  words_checked;
    int unsigned  cells_sent;
    int unsigned  idle_cycles;
    int unsigned  stall_left;
    bit           gaps_on;

    fog_corner_code_change_tracker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // corner code of the current entry; advances the raster position and the box
    function automatic corner_word_t predict_corner_word(bit explored, bit visible);
        corner_word_t w;
        int unsigned  ew;
        int unsigned  eh;
        int unsigned  addr;
        bit [1:0]     se;
        bit [1:0]     ne;
        bit [1:0]     nw;
        bit [1:0]     sw;
        bit [7:0]     code;
        bit [7:0]     stored;
        bit           col_ok;
        bit           cell_ok;
        bit           last_col;
        ew = grid_wide + 1;
        if (ew > MAX_ENTRIES_WIDE) ew = MAX_ENTRIES_WIDE;
        eh = grid_high + 1;
        if (eh > MAX_ENTRIES_HIGH) eh = MAX_ENTRIES_HIGH;
        col_ok  = grid_col < MAX_ENTRIES_WIDE;
        cell_ok = col_ok && grid_row < MAX_ENTRIES_HIGH;
        se = 2'b00;
        ne = 2'b00;
        stored = 8'h00;
        // dark bits: bit 0 unexplored, bit 1 unseen; cells off the map are clear
        if (grid_col < grid_wide && grid_row < grid_high) se = {~visible, ~explored};
        if (grid_row > 0 && col_ok) ne = row_dark[grid_col];
        nw = (grid_col > 0) ? diag_dark : 2'b00;
        sw = (grid_col > 0) ? left_dark : 2'b00;
        code = {se[1], sw[1], ne[1], nw[1], se[0], sw[0], ne[0], nw[0]};
        // compare with the stored code and write back
        if (cell_ok) begin
            addr = grid_row * MAX_ENTRIES_WIDE + grid_col;
            stored = code_mem[addr];
            code_mem[addr] = code;
        end
        w.changed = code != stored;
        if (col_ok) row_dark[grid_col] = se;
        diag_dark = ne;
        left_dark = se;
        // grow the box of changed entries
        if (w.changed) begin
            if (!box_valid) begin
                box_min_x = grid_col;
                box_max_x = grid_col;
                box_min_y = grid_row;
                box_max_y = grid_row;
                box_valid = 1'b1;
            end else begin
                if (grid_col < box_min_x) box_min_x = grid_col;
                if (grid_col > box_max_x) box_max_x = grid_col;
                if (grid_row < box_min_y) box_min_y = grid_row;
                if (grid_row > box_max_y) box_max_y = grid_row;
            end
        end
        last_col = grid_col >= ew - 1;
        w.frame_end = last_col && grid_row >= eh - 1;
        w.ex = grid_col;
        w.ey = grid_row;
        w.code = code;
        w.any_changed = w.frame_end && box_valid;
        w.min_x = w.any_changed ? box_min_x : 8'h00;
        w.min_y = w.any_changed ? box_min_y : 8'h00;
        w.max_x = w.any_changed ? box_max_x : 8'h00;
        w.max_y = w.any_changed ? box_max_y : 8'h00;
        // raster step; row wraps at the last column, frame wraps at the last row
        if (last_col) begin
            grid_col = 8'h00;
            grid_row = w.frame_end ? 8'h00 : grid_row + 8'h01;
        end else begin
            grid_col = grid_col + 8'h01;
        end
        if (w.frame_end) begin
            box_valid = 1'b0;
            box_min_x = BOX_MIN_RST;
            box_min_y = BOX_MIN_RST;
            box_max_x = BOX_MAX_RST;
            box_max_y = BOX_MAX_RST;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch on word %0d, %s: got 0x%0h, expected 0x%0h",
                     words_checked, what, got, want);
        mismatches++;
    endtask

    // accepted words: predict on s_, check on m_, config writes, watchdog
    always @(posedge aclk) begin : word_monitor
        corner_word_t got;
        corner_word_t want;
        int unsigned  got_f [10];
        int unsigned  want_f [10];
        bit           moved;
        moved = 1'b0;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MAP_CELLS_WIDE: grid_wide = cfg_wdata;
                    REG_MAP_CELLS_HIGH: grid_high = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pending_words.insert(pending_words.size(),
                                     predict_corner_word(s_tdata[0], s_tdata[1]));
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                got.ex          = m_tdata[7:0];
                got.ey          = m_tdata[15:8];
                got.code        = m_tdata[23:16];
                got.changed     = m_tdata[24];
                got.any_changed = m_tdata[25];
                got.min_x       = m_tdata[33:26];
                got.min_y       = m_tdata[41:34];
                got.max_x       = m_tdata[49:42];
                got.max_y       = m_tdata[57:50];
                got.frame_end   = m_tlast;
                if (pending_words.size() == 0) begin
                    report_mismatch("word with nothing pending", m_tdata[31:0], 0);
                end else begin
                    want = pending_words.pop_front();
                    got_f  = '{got.ex, got.ey, got.code, got.changed, got.frame_end,
                               got.any_changed, got.min_x, got.min_y, got.max_x, got.max_y};
                    want_f = '{want.ex, want.ey, want.code, want.changed, want.frame_end,
                               want.any_changed, want.min_x, want.min_y, want.max_x,
                               want.max_y};
                    for (int i = 0; i < 10; i++)
                        if (got_f[i] != want_f[i])
                            report_mismatch(field_names[i], got_f[i], want_f[i]);
                end
                words_checked++;
            end
        end
        if (moved) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_CYCLES);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one cell word on s_, with an optional gap first; returns on the falling edge
    task automatic send_cell(input bit explored, input bit visible);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-2){1'b0}}, visible, explored};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        cells_sent++;
    endtask

    // cell word for the entry that comes next, read from the fog map
    task automatic send_map_cell();
        bit [1:0] fog;
        if (grid_col < grid_wide && grid_row < grid_high) begin
            if ($urandom_range(0, 39) == 0)
                fog_map[grid_row][grid_col] ^= 2'($urandom_range(1, 3));
            fog = fog_map[grid_row][grid_col];
        end else begin
            // off-map cell, its bits do not matter
            fog = 2'($urandom_range(0, 3));
        end
        send_cell(fog[0], fog[1]);
    endtask

    // stop sending and let every pending word come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_words.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_map_size(input logic [CFG_W-1:0] wide, input logic [CFG_W-1:0] high);
        wait_idle();
        write_reg(REG_MAP_CELLS_WIDE, wide);
        write_reg(REG_MAP_CELLS_HIGH, high);
    endtask

    task automatic reset_block();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        // clearing pass of the code store
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
    endtask

    // 1x1 map: every dark combination of the one cell, then a frame with no change
    task automatic test_corner_patterns();
        bit [1:0] patterns [5] = '{2'b00, 2'b11, 2'b10, 2'b01, 2'b01};
        set_map_size(8'd1, 8'd1);
        for (int f = 0; f < 5; f++) begin
            send_cell(patterns[f][0], patterns[f][1]);
            repeat (3) send_cell(~patterns[f][0], ~patterns[f][1]);
        end
    endtask

    // zero-sized registers: single-entry and single-row grids with all cells off the map
    task automatic test_empty_sizes();
        set_map_size(8'd0, 8'd0);
        send_cell(1'b0, 1'b0);
        send_cell(1'b1, 1'b1);
        set_map_size(8'd2, 8'd0);
        repeat (3) send_cell(1'b0, 1'b1);
    endtask

    // widest and tallest grids the registers allow
    task automatic test_widest_grids();
        for (int y = 0; y < 256; y++)
            for (int x = 0; x < 256; x++)
                fog_map[y][x] = 2'($urandom_range(0, 3));
        set_map_size(8'd255, 8'd1);
        repeat (512) send_map_cell();
        set_map_size(8'd0, 8'd255);
        repeat (256) send_map_cell();
    endtask

    // shrink the grid in the middle of a frame: row wrap, then early frame end
    task automatic test_midframe_resize();
        set_map_size(8'd5, 8'd5);
        repeat (10) send_map_cell();
        wait_idle();
        write_reg(REG_MAP_CELLS_WIDE, 8'd2);
        repeat (8) send_map_cell();
        wait_idle();
        write_reg(REG_MAP_CELLS_HIGH, 8'd1);
        repeat (6) send_map_cell();
    endtask

    // random grid sizes, whole and partial frames, gaps on most phases
    task automatic test_random_frames();
        int unsigned target;
        int unsigned wide;
        int unsigned high;
        int unsigned count;
        target = cells_sent + 450;
        while (cells_sent < target) begin
            gaps_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 5) == 0) begin
                wide = $urandom_range(100, 255);
                high = $urandom_range(0, 1);
            end else begin
                wide = $urandom_range(0, 9);
                high = $urandom_range(0, 7);
            end
            set_map_size(wide[7:0], high[7:0]);
            count = $urandom_range(1, 3) * (wide + 1) * (high + 1) + $urandom_range(0, 3);
            if (count > 200) count = $urandom_range(20, 200);
            repeat (count) send_map_cell();
        end
    endtask

    // back-to-back words with no gaps on either side
    task automatic test_steady_stream();
        gaps_on = 1'b0;
        set_map_size(8'd7, 8'd4);
        repeat (120) send_map_cell();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MAP_CELLS_WIDE;
        cfg_wdata = '0;
        gaps_on   = 1'b1;
        reset_block();
        test_corner_patterns();
        test_empty_sizes();
        test_widest_grids();
        test_midframe_resize();
        test_random_frames();
        test_steady_stream();
        wait_idle();
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
